### sv/mwmu_pkg.sv
// Shared types and constants for the maze wall map update block.
// Depends on nothing; maze_wall_map_update uses it by scoped names.
`default_nettype none

package mwmu_pkg;

	localparam int unsigned COORD_W  = 4;
	localparam int unsigned HEAD_W   = 2;
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned THR_W    = 12;

	localparam logic [THR_W-1:0] THR_RESET = 12'd2048;

	// Item kinds carried in tuser.
	localparam logic REQ_SENSE = 1'b0;
	localparam logic REQ_BLOCK = 1'b1;

	// Absolute directions, also the heading codes.
	localparam logic [HEAD_W-1:0] DIR_NORTH = 2'd0;
	localparam logic [HEAD_W-1:0] DIR_EAST  = 2'd1;
	localparam logic [HEAD_W-1:0] DIR_SOUTH = 2'd2;
	localparam logic [HEAD_W-1:0] DIR_WEST  = 2'd3;

	// Direction minus heading, modulo four, names the sensor that looks that way.
	localparam logic [HEAD_W-1:0] REL_FRONT = 2'd0;
	localparam logic [HEAD_W-1:0] REL_RIGHT = 2'd1;
	localparam logic [HEAD_W-1:0] REL_LEFT  = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_LEFT_THR  = 2'd0;
	localparam logic [1:0] REG_FRONT_THR = 2'd1;
	localparam logic [1:0] REG_RIGHT_THR = 2'd2;

	typedef struct packed {
		logic                req_type;
		logic [COORD_W-1:0]  cell_x;
		logic [COORD_W-1:0]  cell_y;
		logic [HEAD_W-1:0]   heading;
		logic [SAMPLE_W-1:0] left_sample;
		logic [SAMPLE_W-1:0] front_sample;
		logic [SAMPLE_W-1:0] right_sample;
	} item_t;

endpackage

`default_nettype wire

### sv/maze_wall_map_update.sv
// Top level of the maze wall map update block: wall bitmaps, thresholds, stream ports.
// Depends on mwmu_pkg for field widths, codes and the item type.
//
//  channel   direction  protocol   payload
//  s_*       in         stream     tdata: cell_x, cell_y, heading, samples; tuser: req_type
//  m_*       out        stream     tdata: wall_north, wall_east, wall_south, wall_west
//  p*        in/out     APB        left, front and right thresholds at 0x0, 0x4, 0x8
//
// One item per cycle while the output is not stalled: an accepted item is held in the input
// register, then the map is read, updated and the four walls are registered in the same edge.
// A stalled result holds the output register; the input register takes a new item while
// it is empty or once the result moves on. Reset loads the start-cell east wall and the
// thresholds.
`default_nettype none

module maze_wall_map_update #(
	parameter int MAZE_SIDE = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Slave stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [3:0] cell_x, [7:4] cell_y, [9:8] heading, [21:10] left_sample,
	// [33:22] front_sample, [45:34] right_sample, [47:46] zero
	input  wire logic [47:0] s_tdata,
	// [0] req_type
	input  wire logic        s_tuser,
	// Master stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] wall_north, [1] wall_east, [2] wall_south, [3] wall_west, [7:4] zero
	output logic [7:0]       m_tdata,
	// Configuration.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int ROWS = MAZE_SIDE - 1;

	// East wall of the start cell, column 0 row 0.
	localparam logic [MAZE_SIDE-1:0] START_EAST = MAZE_SIDE'(1);

	// Input stage.
	logic                                 vld_s1;
	mwmu_pkg::item_t                      item_s1;

	// Wall maps: hwall_q[r][c] is between rows r and r+1, vwall_q[c][r] between
	// columns c and c+1.
	logic [MAZE_SIDE-1:0]                 hwall_q [ROWS];
	logic [MAZE_SIDE-1:0]                 vwall_q [ROWS];

	logic [mwmu_pkg::THR_W-1:0]           left_thr_q;
	logic [mwmu_pkg::THR_W-1:0]           front_thr_q;
	logic [mwmu_pkg::THR_W-1:0]           right_thr_q;

	logic                                 out_vld_q;
	logic [3:0]                           walls_q;

	logic                                 advance;
	logic                                 in_maze;
	logic                                 seen_left;
	logic                                 seen_front;
	logic                                 seen_right;
	logic [mwmu_pkg::HEAD_W-1:0]          rel_dir [4];
	logic [3:0]                           set_dir;
	logic [3:0]                           rd_dir;
	logic [3:0]                           border;
	logic [3:0]                           walls_d;
	logic                                 cfg_wr;
	int                                   xi;
	int                                   yi;

	assign advance  = !out_vld_q || m_tready;
	assign s_tready = !vld_s1 || advance;

	assign xi      = int'(item_s1.cell_x);
	assign yi      = int'(item_s1.cell_y);
	assign in_maze = (xi < MAZE_SIDE) && (yi < MAZE_SIDE);

	assign seen_left  = item_s1.left_sample  > left_thr_q;
	assign seen_front = item_s1.front_sample > front_thr_q;
	assign seen_right = item_s1.right_sample > right_thr_q;

	// Turn the relative sightings into absolute walls to set; a block request sets all four.
	always_comb begin
		for (int d = 0; d < 4; d++) begin
			rel_dir[d] = 2'(d) - item_s1.heading;
			if (item_s1.req_type == mwmu_pkg::REQ_BLOCK) begin
				set_dir[d] = 1'b1;
			end else begin
				case (rel_dir[d])
					mwmu_pkg::REL_FRONT: set_dir[d] = seen_front;
					mwmu_pkg::REL_RIGHT: set_dir[d] = seen_right;
					mwmu_pkg::REL_LEFT:  set_dir[d] = seen_left;
					default:             set_dir[d] = 1'b0;
				endcase
			end
		end
	end

	assign border[mwmu_pkg::DIR_NORTH] = (yi == MAZE_SIDE - 1);
	assign border[mwmu_pkg::DIR_EAST]  = (xi == MAZE_SIDE - 1);
	assign border[mwmu_pkg::DIR_SOUTH] = (yi == 0);
	assign border[mwmu_pkg::DIR_WEST]  = (xi == 0);

	// Stored walls around the cell; bits that fall on the border stay zero here.
	always_comb begin
		rd_dir = '0;
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < MAZE_SIDE; c++) begin
				if (r == yi && c == xi) begin
					rd_dir[mwmu_pkg::DIR_NORTH] = hwall_q[r][c];
				end
				if (r + 1 == yi && c == xi) begin
					rd_dir[mwmu_pkg::DIR_SOUTH] = hwall_q[r][c];
				end
			end
		end
		for (int c = 0; c < ROWS; c++) begin
			for (int r = 0; r < MAZE_SIDE; r++) begin
				if (c == xi && r == yi) begin
					rd_dir[mwmu_pkg::DIR_EAST] = vwall_q[c][r];
				end
				if (c + 1 == xi && r == yi) begin
					rd_dir[mwmu_pkg::DIR_WEST] = vwall_q[c][r];
				end
			end
		end
	end

	assign walls_d = in_maze ? (border | rd_dir | set_dir) : 4'hF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= mwmu_pkg::item_t'({s_tuser, s_tdata[3:0], s_tdata[7:4],
				s_tdata[9:8], s_tdata[21:10], s_tdata[33:22], s_tdata[45:34]});
		end
	end

	// The map takes the update in the same edge that the result is registered, so
	// the next item already sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				hwall_q[r] <= '0;
				vwall_q[r] <= (r == 0) ? START_EAST : '0;
			end
		end else if (vld_s1 && advance && in_maze) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < MAZE_SIDE; c++) begin
					if ((r == yi && c == xi && set_dir[mwmu_pkg::DIR_NORTH]) ||
					    (r + 1 == yi && c == xi && set_dir[mwmu_pkg::DIR_SOUTH])) begin
						hwall_q[r][c] <= 1'b1;
					end
				end
			end
			for (int c = 0; c < ROWS; c++) begin
				for (int r = 0; r < MAZE_SIDE; r++) begin
					if ((c == xi && r == yi && set_dir[mwmu_pkg::DIR_EAST]) ||
					    (c + 1 == xi && r == yi && set_dir[mwmu_pkg::DIR_WEST])) begin
						vwall_q[c][r] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			walls_q <= walls_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0000, walls_q};

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_thr_q  <= mwmu_pkg::THR_RESET;
			front_thr_q <= mwmu_pkg::THR_RESET;
			right_thr_q <= mwmu_pkg::THR_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				mwmu_pkg::REG_LEFT_THR:  left_thr_q  <= pwdata[mwmu_pkg::THR_W-1:0];
				mwmu_pkg::REG_FRONT_THR: front_thr_q <= pwdata[mwmu_pkg::THR_W-1:0];
				mwmu_pkg::REG_RIGHT_THR: right_thr_q <= pwdata[mwmu_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			mwmu_pkg::REG_LEFT_THR:  prdata = {20'd0, left_thr_q};
			mwmu_pkg::REG_FRONT_THR: prdata = {20'd0, front_thr_q};
			mwmu_pkg::REG_RIGHT_THR: prdata = {20'd0, right_thr_q};
			default:                 prdata = '0;
		endcase
	end

endmodule

`default_nettype wire
